FILE: rtl/tsc_pkg.sv
// Shared types, constants and helper functions for the token scanner.
// No dependencies; imported by tsc_step, tsc_fifo and the top-level scanner.
package tsc_pkg;

    localparam int NUM_STATES    = 20;
    localparam int NUM_COLUMNS   = 129;
    localparam int POSITION_BITS = 20;
    localparam int ROW_BITS      = 16;

    localparam int STATE_BITS  = $clog2(NUM_STATES);
    localparam int TABLE_DEPTH = NUM_STATES * NUM_COLUMNS;
    localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);

    localparam int ACTION_BITS = 8;
    localparam int CHAR_BITS   = 8;
    localparam int KIND_W      = 7;
    localparam int SPAN_W      = 20;
    localparam int ROW_OUT_W   = 16;

    localparam int ERROR_ACTION = -99;
    localparam int WIDE_COLUMN  = 128;

    localparam logic [CHAR_BITS-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_BITS-1:0] CHAR_TAB   = 8'h09;
    localparam logic [CHAR_BITS-1:0] CHAR_CR    = 8'h0D;
    localparam logic [CHAR_BITS-1:0] CHAR_LF    = 8'h0A;

    localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
    localparam logic [ROW_BITS-1:0]      ROW_MAX = '1;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        REQ_LOAD    = 2'd0,
        REQ_CHAR    = 2'd1,
        REQ_RESTART = 2'd2
    } t_req;

    typedef enum logic [1:0] {
        ACT_ERROR,
        ACT_EMIT,
        ACT_NEXT
    } t_act_class;

    typedef struct packed {
        logic [STATE_BITS-1:0]    scan_state;
        logic [ROW_BITS-1:0]      row;
        logic [POSITION_BITS-1:0] pos;
        logic [POSITION_BITS-1:0] first;
        logic [POSITION_BITS-1:0] last;
        logic                     seen;
        logic                     halted;
    } t_track;

    localparam t_track TRACK_RESET = '{
        scan_state: '0,
        row:        ROW_BITS'(1),
        pos:        '0,
        first:      '0,
        last:       '0,
        seen:       1'b0,
        halted:     1'b0
    };

    typedef struct packed {
        logic                 valid;
        logic                 restart;
        logic [CHAR_BITS-1:0] char_code;
    } t_pend;

    typedef struct packed {
        logic                 is_error;
        logic [KIND_W-1:0]    token_kind;
        logic [SPAN_W-1:0]    token_start;
        logic [SPAN_W-1:0]    token_length;
        logic [ROW_OUT_W-1:0] token_row;
        logic                 last;
    } t_result;

    function automatic logic [ADDR_BITS-1:0] tbl_addr(input int st, input int col);
        return ADDR_BITS'(st * NUM_COLUMNS + col);
    endfunction

    function automatic int col_of(input logic [CHAR_BITS-1:0] c);
        return (int'(c) < WIDE_COLUMN) ? int'(c) : WIDE_COLUMN;
    endfunction

    function automatic t_act_class classify(input logic signed [ACTION_BITS-1:0] a);
        if (int'(a) <= ERROR_ACTION || int'(a) >= NUM_STATES) begin
            return ACT_ERROR;
        end else if (a < 0) begin
            return ACT_EMIT;
        end
        return ACT_NEXT;
    endfunction

    function automatic t_result error_res(input logic [ROW_BITS-1:0] row);
        t_result r;
        r              = '0;
        r.is_error     = 1'b1;
        r.token_row    = ROW_OUT_W'(row);
        return r;
    endfunction

    function automatic t_result token_res(input logic signed [ACTION_BITS-1:0] a,
                                          input t_track t);
        t_result r;
        r            = '0;
        r.token_kind = KIND_W'(-int'(a));
        r.token_row  = ROW_OUT_W'(t.row);
        if (t.seen) begin
            r.token_start  = SPAN_W'(t.first);
            r.token_length = SPAN_W'(t.last - t.first + POSITION_BITS'(1));
        end
        return r;
    endfunction

    function automatic t_track take_char(input t_track t, input logic blank);
        t_track n;
        n = t;
        if (!blank) begin
            if (!n.seen) begin
                n.first = n.pos;
                n.seen  = 1'b1;
            end
            n.last = n.pos;
        end
        return n;
    endfunction

    function automatic t_track advance_pos(input t_track t);
        t_track n;
        n = t;
        if (n.pos != POS_MAX) begin
            n.pos = n.pos + POSITION_BITS'(1);
        end
        return n;
    endfunction

endpackage

FILE: rtl/tsc_ram.sv
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies; holds the scanner action table.
module tsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic [ADDR_W-1:0] i_rd_addr_a,
    input  logic [ADDR_W-1:0] i_rd_addr_b,
    output logic [WIDTH-1:0]  o_rd_data_a,
    output logic [WIDTH-1:0]  o_rd_data_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data_a <= r_mem[i_rd_addr_a];
        o_rd_data_b <= r_mem[i_rd_addr_b];
    end

endmodule

FILE: rtl/tsc_step.sv
// Per-character decode: classifies the first table lookup, and the second when the first
// emits a token; builds results and the next tracking state. Depends on tsc_pkg.
module tsc_step import tsc_pkg::*; (
    input  t_track                  i_track,
    input  t_pend                   i_pend,
    input  logic [ACTION_BITS-1:0]  i_action_a,
    input  logic [ACTION_BITS-1:0]  i_action_b,
    output t_track                  o_track,
    output t_result                 o_res_first,
    output t_result                 o_res_second,
    output logic [1:0]              o_push
);

    always_comb begin
        t_track                         trk;
        logic signed [ACTION_BITS-1:0]  act_a;
        logic signed [ACTION_BITS-1:0]  act_b;
        logic                           blank;

        trk          = i_track;
        act_a        = signed'(i_action_a);
        act_b        = signed'(i_action_b);
        blank        = (i_pend.char_code == CHAR_SPACE) || (i_pend.char_code == CHAR_TAB) ||
                       (i_pend.char_code == CHAR_CR)    || (i_pend.char_code == CHAR_LF);
        o_track      = i_track;
        o_res_first  = '0;
        o_res_second = '0;
        o_push       = 2'd0;

        if (i_pend.valid) begin
            if (i_pend.restart) begin
                o_track = TRACK_RESET;
            end else if (!i_track.halted) begin
                if (i_pend.char_code == CHAR_LF && trk.row != ROW_MAX) begin
                    trk.row = trk.row + ROW_BITS'(1);
                end
                unique case (classify(act_a))
                    ACT_ERROR: begin
                        o_res_first = error_res(trk.row);
                        trk.halted  = 1'b1;
                        o_push      = 2'd1;
                    end
                    ACT_EMIT: begin
                        o_res_first    = token_res(act_a, trk);
                        trk.seen       = 1'b0;
                        trk.first      = '0;
                        trk.last       = '0;
                        trk.scan_state = '0;
                        unique case (classify(act_b))
                            ACT_ERROR: begin
                                o_res_second = error_res(trk.row);
                                trk.halted   = 1'b1;
                                o_push       = 2'd2;
                            end
                            ACT_EMIT: begin
                                o_res_second = token_res(act_b, trk);
                                trk          = advance_pos(trk);
                                o_push       = 2'd2;
                            end
                            ACT_NEXT: begin
                                trk.scan_state = STATE_BITS'(act_b);
                                trk            = advance_pos(take_char(trk, blank));
                                o_push         = 2'd1;
                            end
                            default: begin
                                o_push = 2'd1;
                            end
                        endcase
                    end
                    ACT_NEXT: begin
                        trk.scan_state = STATE_BITS'(act_a);
                        trk            = advance_pos(take_char(trk, blank));
                    end
                    default: begin
                        o_push = 2'd0;
                    end
                endcase
                o_res_first.last  = (o_push == 2'd1);
                o_res_second.last = (o_push == 2'd2);
                o_track           = trk;
            end
        end
    end

endmodule

FILE: rtl/tsc_fifo.sv
// Result queue: takes up to two results per cycle, delivers at most one.
// Depends on tsc_pkg.
module tsc_fifo import tsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic [1:0]            i_push,
    input  t_result               i_entry_a,
    input  t_result               i_entry_b,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_head,
    output logic [FIFO_CNT_W-1:0] o_count
);

    t_result               r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] r_wr;
    logic [FIFO_PTR_W-1:0] r_rd;
    logic [FIFO_CNT_W-1:0] r_count;
    logic                  pop;

    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign o_count = r_count;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push != 2'd0) begin
            r_mem[r_wr] <= i_entry_a;
        end
        if (i_push == 2'd2) begin
            r_mem[r_wr + FIFO_PTR_W'(1)] <= i_entry_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + FIFO_PTR_W'(i_push);
            r_rd    <= r_rd + FIFO_PTR_W'(pop);
            r_count <= r_count + FIFO_CNT_W'(i_push) - FIFO_CNT_W'(pop);
        end
    end

endmodule

FILE: rtl/table_driven_token_scanner_unit.sv
// Table-driven token scanner, top level. Uses tsc_pkg, tsc_ram, tsc_step, tsc_fifo.
// Order: a character and its table lookups are registered, then its results are
// written into the result queue; a second result (token emit re-lookup) follows the first.
// Throughput: one transaction per cycle while the result queue has room; the queue drains
// one result per cycle while i_out_ready is high, so two-result characters stall input.
// Reset (synchronous, active low) clears scan state and queue; the table is not cleared.
module table_driven_token_scanner_unit import tsc_pkg::*; (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [1:0]                    i_req_type,
    input  logic [4:0]                    i_table_row,
    input  logic [7:0]                    i_table_col,
    input  logic signed [ACTION_BITS-1:0] i_table_action,
    input  logic [CHAR_BITS-1:0]          i_source_char,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic                          o_is_error,
    output logic [KIND_W-1:0]             o_token_kind,
    output logic [SPAN_W-1:0]             o_token_start,
    output logic [SPAN_W-1:0]             o_token_length,
    output logic [ROW_OUT_W-1:0]          o_token_row,
    output logic                          o_last
);

    t_track                  r_track;
    t_track                  n_track;
    t_pend                   r_pend;
    t_pend                   n_pend;
    logic [ACTION_BITS-1:0]  rd_a;
    logic [ACTION_BITS-1:0]  rd_b;
    t_result                 res_first;
    t_result                 res_second;
    t_result                 head;
    logic [1:0]              push;
    logic [FIFO_CNT_W-1:0]   fifo_count;
    logic                    accept;
    logic                    load_en;
    logic [ADDR_BITS-1:0]    wr_addr;
    logic [ADDR_BITS-1:0]    rd_addr_a;
    logic [ADDR_BITS-1:0]    rd_addr_b;

    assign o_in_ready = ({1'b0, fifo_count} + (FIFO_CNT_W + 1)'(push))
                        <= (FIFO_CNT_W + 1)'(FIFO_DEPTH - 2);
    assign accept     = i_in_valid && o_in_ready;

    assign load_en   = accept && (i_req_type == REQ_LOAD) &&
                       (int'(i_table_row) < NUM_STATES) && (int'(i_table_col) < NUM_COLUMNS);
    assign wr_addr   = tbl_addr(int'(i_table_row), int'(i_table_col));
    assign rd_addr_a = tbl_addr(int'(n_track.scan_state), col_of(i_source_char));
    assign rd_addr_b = tbl_addr(0, col_of(i_source_char));

    tsc_ram #(
        .WIDTH (ACTION_BITS),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk       (i_clk),
        .i_wr_en     (load_en),
        .i_wr_addr   (wr_addr),
        .i_wr_data   (i_table_action),
        .i_rd_addr_a (rd_addr_a),
        .i_rd_addr_b (rd_addr_b),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    tsc_step u_step (
        .i_track      (r_track),
        .i_pend       (r_pend),
        .i_action_a   (rd_a),
        .i_action_b   (rd_b),
        .o_track      (n_track),
        .o_res_first  (res_first),
        .o_res_second (res_second),
        .o_push       (push)
    );

    always_comb begin
        n_pend.valid     = accept &&
                           ((i_req_type == REQ_CHAR) || (i_req_type == REQ_RESTART));
        n_pend.restart   = (i_req_type == REQ_RESTART);
        n_pend.char_code = i_source_char;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track      <= TRACK_RESET;
            r_pend.valid <= 1'b0;
        end else begin
            r_track      <= n_track;
            r_pend.valid <= n_pend.valid;
        end
        r_pend.restart   <= n_pend.restart;
        r_pend.char_code <= n_pend.char_code;
    end

    tsc_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_entry_a (res_first),
        .i_entry_b (res_second),
        .i_pop     (i_out_ready),
        .o_valid   (o_out_valid),
        .o_head    (head),
        .o_count   (fifo_count)
    );

    assign o_is_error     = head.is_error;
    assign o_token_kind   = head.token_kind;
    assign o_token_start  = head.token_start;
    assign o_token_length = head.token_length;
    assign o_token_row    = head.token_row;
    assign o_last         = head.last;

endmodule
